[sv/u8dw_pkg.sv]
// Shared types, code point ranges and width classification for the UTF-8 column counter.
package u8dw_pkg;

  localparam int CP_BITS = 21;
  localparam int PEND_BITS = 2;

  // Number of continuation bytes still expected.
  localparam logic [PEND_BITS-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_BITS-1:0] PEND_ONE = 2'd1;
  localparam logic [PEND_BITS-1:0] PEND_TWO = 2'd2;
  localparam logic [PEND_BITS-1:0] PEND_THREE = 2'd3;

  typedef logic [CP_BITS-1:0] code_point_t;
  typedef logic [PEND_BITS-1:0] pend_t;

  // Decoder result for one byte against the current sequence state.
  typedef struct packed {
    code_point_t acc_next;
    pend_t pend_next;
    logic add_en;
    logic add_two;
  } decode_t;

  // True when a code point occupies two terminal columns.
  function automatic logic is_wide(input code_point_t cp);
    logic w;
    w = (cp >= 21'h01100 && cp <= 21'h0115F) ||
        (cp >= 21'h02329 && cp <= 21'h0232A) ||
        (cp >= 21'h02E80 && cp <= 21'h0303E) ||
        (cp >= 21'h03040 && cp <= 21'h033BF) ||
        (cp >= 21'h03400 && cp <= 21'h04DBF) ||
        (cp >= 21'h04E00 && cp <= 21'h0A4CF) ||
        (cp >= 21'h0AC00 && cp <= 21'h0D7AF) ||
        (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
        (cp >= 21'h0FE30 && cp <= 21'h0FE6F) ||
        (cp >= 21'h0FF01 && cp <= 21'h0FF60) ||
        (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) ||
        (cp >= 21'h20000);
    return w;
  endfunction

endpackage

[sv/u8dw_decode.sv]
// Byte decoder: sequence tracking, code point assembly and column class of one byte.
module u8dw_decode
  import u8dw_pkg::*;
(
  input  logic [7:0]  text_byte,
  input  logic        last,
  input  pend_t       pend,
  input  code_point_t acc,
  output decode_t     dec
);

  always_comb begin
    dec.acc_next = acc;
    dec.pend_next = pend;
    dec.add_en = 1'b0;
    dec.add_two = 1'b0;
    if (pend != PEND_NONE) begin
      // Absorb any byte as a continuation, low six bits only.
      dec.acc_next = {acc[CP_BITS-7:0], text_byte[5:0]};
      dec.pend_next = pend - PEND_ONE;
      // Count a finished code point, or a partial one cut short at the end.
      dec.add_en = (dec.pend_next == PEND_NONE) || last;
      dec.add_two = is_wide(dec.acc_next);
    end else if (text_byte[7] == 1'b0) begin
      dec.add_en = 1'b1;
      dec.add_two = is_wide(code_point_t'(text_byte));
    end else if (text_byte[7:5] == 3'b110) begin
      dec.acc_next = code_point_t'(text_byte[4:0]);
      dec.pend_next = PEND_ONE;
      dec.add_en = last;
      dec.add_two = is_wide(dec.acc_next);
    end else if (text_byte[7:4] == 4'b1110) begin
      dec.acc_next = code_point_t'(text_byte[3:0]);
      dec.pend_next = PEND_TWO;
      dec.add_en = last;
      dec.add_two = is_wide(dec.acc_next);
    end else if (text_byte[7:3] == 5'b11110) begin
      dec.acc_next = code_point_t'(text_byte[2:0]);
      dec.pend_next = PEND_THREE;
      dec.add_en = last;
      dec.add_two = is_wide(dec.acc_next);
    end else begin
      // Stray continuation or invalid lead: one column.
      dec.add_en = 1'b1;
    end
  end

endmodule

[sv/utf8_display_width_counter_core.sv]
// Top level: input register, decoder, saturating column count and result register.
// Takes one UTF-8 byte per cycle, sustained unless a final byte is held, and presents
// the column total of a string in the result register once its final byte leaves the input
// register. Each byte is decoded and added to the saturating COUNT_BITS-wide total while it
// is in the input register; a final byte waits there only while the previous total is still
// stalled at the output, and the count starts over from zero on the byte that follows it.
module utf8_display_width_counter_core
  import u8dw_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_string,
  output logic        columns_valid,
  input  logic        columns_stall,
  output logic [15:0] display_columns
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_adv;
  logic        accept;

  pend_t       pend;
  code_point_t acc;
  logic [COUNT_BITS-1:0] running;
  logic [COUNT_BITS-1:0] running_next;
  logic [COUNT_BITS:0]   sum;
  decode_t     dec;

  // Hold a final byte while the previous total has not been taken.
  assign s1_adv = s1_valid && !(s1_last && columns_valid && columns_stall);
  assign byte_stall = s1_valid && !s1_adv;
  assign accept = byte_valid && !byte_stall;

  u8dw_decode u_decode (
    .text_byte (s1_byte),
    .last      (s1_last),
    .pend      (pend),
    .acc       (acc),
    .dec       (dec)
  );

  always_comb begin
    sum = {1'b0, running} + (dec.add_two ? (COUNT_BITS+1)'(2) : (COUNT_BITS+1)'(1));
    running_next = running;
    if (dec.add_en) begin
      running_next = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_byte <= text_byte;
      s1_last <= end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= PEND_NONE;
      acc <= '0;
      running <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        pend <= PEND_NONE;
        acc <= '0;
        running <= '0;
      end else begin
        pend <= dec.pend_next;
        acc <= dec.acc_next;
        running <= running_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      columns_valid <= 1'b1;
    end else if (!columns_stall) begin
      columns_valid <= 1'b0;
    end
    if (s1_adv && s1_last) begin
      display_columns <= 16'(running_next);
    end
  end

  a_stall_only_on_final : assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (s1_valid && s1_last && columns_valid))
    else $error("input stalled without a final byte waiting on the result");

  a_final_gives_result : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> columns_valid)
    else $error("final byte advanced without a result");

  a_final_clears_state : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (pend == PEND_NONE && acc == '0 && running == '0))
    else $error("sequence state not cleared after final byte");

  a_count_never_drops : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !s1_last) |=> (running >= $past(running)))
    else $error("running column count decreased within a string");

endmodule

[dv/utf8_display_width_counter_core_tb.sv]
// Self-checking testbench for the UTF-8 display column counter core.
`timescale 1ns / 100ps

module utf8_display_width_counter_core_tb
  import u8dw_pkg::*;
();

  localparam int COUNT_BITS = 16;
  localparam longint unsigned COLUMN_CAP = (64'd1 << COUNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_BYTES = 420;
  localparam int LONG_BYTES = 200;
  localparam int ITEM_GOAL = 1250;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  text_byte = 8'h41;
  logic        end_of_string = 1'b0;
  logic        columns_valid;
  logic        columns_stall = 1'b0;
  logic [15:0] display_columns;

  utf8_display_width_counter_core #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .text_byte(text_byte),
    .end_of_string(end_of_string),
    .columns_valid(columns_valid),
    .columns_stall(columns_stall),
    .display_columns(display_columns)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Decoder state mirrored from the block.
  pend_t           cont_left = PEND_NONE;
  code_point_t     cp_build = '0;
  longint unsigned column_tally = 0;

  logic [15:0] column_totals_q[$];
  logic [7:0]  str_q[$];
  logic [15:0] exp_total;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int totals_checked = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;

  typedef struct {
    logic [7:0]  b;
    logic        eos;
    logic        typed;
    logic [15:0] total;
  } dir_row_t;

  dir_row_t dir_rows [24] = '{
    '{8'h41, 1'b1, 1'b1, 16'd1},  // plain ASCII right after reset
    '{8'h01, 1'b1, 1'b1, 16'd1},  // lowest byte
    '{8'h7F, 1'b1, 1'b1, 16'd1},
    '{8'hFF, 1'b1, 1'b1, 16'd1},  // stray, highest byte
    '{8'h80, 1'b1, 1'b1, 16'd1},  // stray continuation
    '{8'hF8, 1'b1, 1'b1, 16'd1},  // stray, first invalid lead
    '{8'hE4, 1'b0, 1'b0, 16'd0},  // U+4E00, wide
    '{8'hB8, 1'b0, 1'b0, 16'd0},
    '{8'h80, 1'b1, 1'b1, 16'd2},
    '{8'hF0, 1'b0, 1'b0, 16'd0},  // U+20000, wide
    '{8'hA0, 1'b0, 1'b0, 16'd0},
    '{8'h80, 1'b0, 1'b0, 16'd0},
    '{8'h80, 1'b1, 1'b1, 16'd2},
    '{8'hF1, 1'b0, 1'b0, 16'd0},  // four-byte lead cut short, partial lands in a wide range
    '{8'h84, 1'b0, 1'b0, 16'd0},
    '{8'h80, 1'b1, 1'b0, 16'd0},
    '{8'hE4, 1'b0, 1'b0, 16'd0},  // ASCII bytes absorbed as continuations
    '{8'h41, 1'b0, 1'b0, 16'd0},
    '{8'h41, 1'b1, 1'b0, 16'd0},
    '{8'hC3, 1'b0, 1'b0, 16'd0},  // two-byte then three-byte code points
    '{8'hA9, 1'b0, 1'b0, 16'd0},
    '{8'hE1, 1'b0, 1'b0, 16'd0},
    '{8'h85, 1'b0, 1'b0, 16'd0},
    '{8'h9F, 1'b1, 1'b0, 16'd0}
  };

  function automatic void wide_range(input int idx, output code_point_t lo,
                                     output code_point_t hi);
    case (idx)
      0:       begin lo = 21'h01100; hi = 21'h0115F; end
      1:       begin lo = 21'h02329; hi = 21'h0232A; end
      2:       begin lo = 21'h02E80; hi = 21'h0303E; end
      3:       begin lo = 21'h03040; hi = 21'h033BF; end
      4:       begin lo = 21'h03400; hi = 21'h04DBF; end
      5:       begin lo = 21'h04E00; hi = 21'h0A4CF; end
      6:       begin lo = 21'h0AC00; hi = 21'h0D7AF; end
      7:       begin lo = 21'h0F900; hi = 21'h0FAFF; end
      8:       begin lo = 21'h0FE30; hi = 21'h0FE6F; end
      9:       begin lo = 21'h0FF01; hi = 21'h0FF60; end
      10:      begin lo = 21'h0FFE0; hi = 21'h0FFE6; end
      default: begin lo = 21'h20000; hi = 21'h1FFFFF; end
    endcase
  endfunction

  function automatic longint unsigned cp_width(input code_point_t cp);
    code_point_t lo, hi;
    for (int i = 0; i < 12; i++) begin
      wide_range(i, lo, hi);
      if (cp >= lo && cp <= hi) return 2;
    end
    return 1;
  endfunction

  function automatic void add_cols(input longint unsigned n);
    column_tally = (column_tally + n > COLUMN_CAP) ? COLUMN_CAP : column_tally + n;
  endfunction

  // Advance the decoder by one byte; returns the string total on its last byte.
  function automatic logic [15:0] decode_and_count(input logic [7:0] b, input logic eos);
    logic [15:0] total;
    total = '0;
    if (cont_left != PEND_NONE) begin
      cp_build = {cp_build[CP_BITS-7:0], b[5:0]};
      cont_left = cont_left - 1'b1;
      if (cont_left == PEND_NONE) add_cols(cp_width(cp_build));
    end else if (!b[7]) begin
      add_cols(cp_width({13'd0, b}));
    end else if (b[7:5] == 3'b110) begin
      cp_build = {16'd0, b[4:0]};
      cont_left = PEND_ONE;
    end else if (b[7:4] == 4'b1110) begin
      cp_build = {17'd0, b[3:0]};
      cont_left = PEND_TWO;
    end else if (b[7:3] == 5'b11110) begin
      cp_build = {18'd0, b[2:0]};
      cont_left = PEND_THREE;
    end else begin
      add_cols(1);
    end
    if (eos) begin
      // count a sequence cut short by its partial code point
      if (cont_left != PEND_NONE) add_cols(cp_width(cp_build));
      total = column_tally[15:0];
      cont_left = PEND_NONE;
      cp_build = '0;
      column_tally = 0;
    end
    return total;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input logic [15:0] typed_total);
    logic [15:0] total;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    text_byte <= b;
    end_of_string <= eos;
    do @(posedge clk); while (byte_stall);
    total = decode_and_count(b, eos);
    bytes_sent++;
    if (eos) begin
      column_totals_q.push_back(typed ? typed_total : total);
      strings_sent++;
    end
  endtask

  task automatic send_string();
    logic [7:0] b;
    while (str_q.size() != 0) begin
      b = str_q.pop_front();
      send_byte(b, str_q.size() == 0, 1'b0, 16'd0);
    end
  endtask

  function automatic code_point_t pick_cp();
    code_point_t lo, hi;
    wide_range($urandom_range(11), lo, hi);
    case ($urandom_range(3))
      0:       return lo - 1'b1;
      1:       return lo;
      2:       return hi;
      default: return hi + 1'b1;
    endcase
  endfunction

  // Encode one code point; a cut sequence keeps only its first bytes.
  task automatic push_char(input code_point_t cp, input logic cut);
    logic [7:0] enc [4];
    int n;
    int keep;
    if (cp < 21'h80) n = 1;
    else if (cp < 21'h800) n = 2;
    else if (cp < 21'h10000) n = 3;
    else n = 4;
    if (n < 4 && $urandom_range(9) == 0) n++;  // overlong form
    if (cut && n == 1) n = $urandom_range(2, 4);
    keep = cut ? $urandom_range(1, n - 1) : n;
    case (n)
      1:       enc[0] = {1'b0, cp[6:0]};
      2:       enc[0] = {3'b110, cp[10:6]};
      3:       enc[0] = {4'b1110, cp[15:12]};
      default: enc[0] = {5'b11110, cp[20:18]};
    endcase
    if (enc[0] == 8'h00) enc[0] = 8'h01;
    for (int i = 1; i < n; i++) begin
      enc[i] = {2'b10, cp[6*(n-1-i) +: 6]};
      // continuation form is not checked, so scramble the tag now and then
      if ($urandom_range(9) == 0) enc[i][7:6] = 2'($urandom_range(3));
      if (enc[i] == 8'h00) enc[i] = 8'h40;
    end
    for (int i = 0; i < keep; i++) str_q.push_back(enc[i]);
  endtask

  task automatic make_random_text();
    int r;
    repeat ($urandom_range(1, 10)) begin
      r = $urandom_range(99);
      if (r < 40) push_char(pick_cp(), 1'b0);
      else if (r < 60)
        push_char(21'($urandom() & ((32'd1 << (5 * $urandom_range(1, 4) + 1)) - 1)), 1'b0);
      else if (r < 75) push_char(21'($urandom_range(1, 127)), 1'b0);
      else if (r < 88) str_q.push_back(8'($urandom_range(1, 255)));
      else if ($urandom_range(1) == 0) str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      else str_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end
    if ($urandom_range(99) < 15) push_char(pick_cp(), 1'b1);
  endtask

  task automatic random_phase(input int goal);
    while (bytes_sent < goal) begin
      make_random_text();
      send_string();
    end
  endtask

  // Result side: check each transfer and drive the stall.
  always @(posedge clk) begin
    if (rst) begin
      columns_stall <= 1'b0;
    end else begin
      if (columns_valid && !columns_stall) begin
        if (column_totals_q.size() == 0) begin
          $error("display_columns: no total expected, got %0d", display_columns);
          mismatches++;
        end else begin
          exp_total = column_totals_q.pop_front();
          totals_checked++;
          if (display_columns !== exp_total) begin
            $error("display_columns: expected %0d, got %0d", exp_total, display_columns);
            mismatches++;
          end
        end
      end
      if (hold_go && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left != 0) begin
        columns_stall <= 1'b1;
        hold_left--;
      end else begin
        columns_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 18;
    recv_idle_pct = 56;
    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].total);
    random_phase(PHASE_BYTES);

    send_idle_pct = 56;
    recv_idle_pct = 18;
    random_phase(2 * PHASE_BYTES);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // hold the output off while one-byte strings keep coming, to back up the input
    hold_go <= 1'b1;
    repeat (30) begin
      str_q.push_back(8'($urandom_range(1, 255)));
      send_string();
    end

    // one long string mixing narrow and wide characters
    while (str_q.size() < LONG_BYTES) begin
      if ($urandom_range(7) == 0) push_char(pick_cp(), 1'b0);
      else push_char(21'($urandom_range(1, 127)), 1'b0);
    end
    send_string();
    random_phase(ITEM_GOAL);

    byte_valid <= 1'b0;
    while (column_totals_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d column totals from %0d strings and %0d bytes in %0d cycles:",
             totals_checked, strings_sent, bytes_sent, cycle_count);
    $display("  corner bytes, cut and malformed sequences, a long string, output hold-off.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[utf8_display_width_counter_core.f]
sv/u8dw_pkg.sv
sv/u8dw_decode.sv
sv/utf8_display_width_counter_core.sv
dv/utf8_display_width_counter_core_tb.sv
